[rtl/ptme_pkg.sv]
// Package for the page table map engine: item types, codes, control structs.
`default_nettype none
package ptme_pkg;

    // Pool size default and fixed table geometry.
    localparam int TABLE_PAGES_DEF   = 64;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W             = 9;

    // Request operations.
    localparam logic [1:0] OP_MAP4K   = 2'd0;
    localparam logic [1:0] OP_UNMAP4K = 2'd1;
    localparam logic [1:0] OP_MAP2M   = 2'd2;
    localparam logic [1:0] OP_INVALID = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNALIGNED = 3'd1;
    localparam logic [2:0] ST_CONFLICT  = 3'd2;
    localparam logic [2:0] ST_NOT_MAPPED = 3'd3;
    localparam logic [2:0] ST_EXHAUSTED = 3'd4;

    // Walk levels: root table down to the 4K leaf table.
    localparam logic [1:0] LVL_PML4 = 2'd3;
    localparam logic [1:0] LVL_PDPT = 2'd2;
    localparam logic [1:0] LVL_PD   = 2'd1;
    localparam logic [1:0] LVL_PT   = 2'd0;

    typedef struct packed {
        logic [1:0]  op;
        logic [47:0] virt_addr;
        logic [51:0] phys_addr;
        logic        write_enable;
        logic        user_access;
        logic        global_page;
        logic        copy_on_write;
        logic        no_execute;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] leaf_entry;
    } t_out_item;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_RD,
        S_EVAL,
        S_FILL,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cap;
        logic chk;
        logic rd;
        logic ev;
        logic fill;
        logic out_load;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic chk_err;
        logic ev_done;
        logic ev_fill;
        logic fill_last;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

[rtl/page_table_map_engine.sv]
// Top level of the page table map engine: controller, datapath and checks.
// The engine keeps a four-level page table in a pool of TABLE_PAGES table pages
// (512 entries each) in one single-port-write memory; pool page 0 is the root at
// the frame written through i_cfg_data. After reset a clearing pass zeroes the
// 512 root entries before the first item is taken. Once an item is taken, it is
// checked, each walk level reads memory and then decides and writes, and the
// result register is loaded once the output register is free. The next item
// can be taken in the cycle after the result is loaded. Every table page
// allocated or 2M leaf split adds a sweep that writes the new page one entry a
// cycle. One item is in work at a time; the result waits in an output register
// while the next is taken.
`default_nettype none
module page_table_map_engine import ptme_pkg::*; #(
    parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_item,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_item,
    input  wire logic        i_cfg_we,
    input  wire logic [39:0] i_cfg_data
);
    t_ctl_cmd cmd;
    t_dp_sts  sts;

    // Sequencer.
    ptme_ctl u_ctl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    // Walk datapath and table store.
    ptme_dp #(.TABLE_PAGES(TABLE_PAGES)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

`ifndef SYNTH
    // A failed request never reports a leaf entry.
    a_err_leaf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status != ST_OK) |-> (o_out_item.leaf_entry == 64'b0))
        else $error("error result carries a leaf entry");

    // Only one item is in work: ready drops right after an item is taken.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("item accepted while another is in work");

    // Status codes stay within the defined set.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.status <= ST_EXHAUSTED))
        else $error("undefined status code");

    // A successful map always writes a present leaf.
    a_ok_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == ST_OK && o_out_item.leaf_entry != 64'b0)
        |-> o_out_item.leaf_entry[0])
        else $error("leaf written without present bit");
`endif
endmodule
`default_nettype wire

[rtl/ptme_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ptme_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32768
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

[rtl/ptme_ctl.sv]
// Controller state machine of the page table map engine.
`default_nettype none
module ptme_ctl import ptme_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_sts  i_sts,
    output t_ctl_cmd      o_cmd
);
    t_state r_state, n_state;

    // State register; reset starts the root page clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.fill = 1'b1;
                if (i_sts.fill_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.cap  = i_in_valid;
                if (i_in_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.chk = 1'b1;
                n_state   = i_sts.chk_err ? S_DONE : S_RD;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.ev = 1'b1;
                if (i_sts.ev_done) begin
                    n_state = S_DONE;
                end else if (i_sts.ev_fill) begin
                    n_state = S_FILL;
                end else begin
                    n_state = S_RD;
                end
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_sts.fill_last) n_state = S_RD;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

[rtl/ptme_dp.sv]
// Datapath of the page table map engine: request, walk registers, table store.
`default_nettype none
module ptme_dp import ptme_pkg::*; #(
    parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_in_item   i_in_item,
    input  wire logic       i_cfg_we,
    input  wire logic [39:0] i_cfg_data,
    input  wire t_ctl_cmd   i_cmd,
    output t_dp_sts         o_sts,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_item       o_out_item
);
    localparam int PW    = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int NW    = $clog2(TABLE_PAGES + 1);
    localparam int AW    = PW + IDX_W;
    localparam int DEPTH = TABLE_PAGES * ENTRIES_PER_TABLE;
    localparam logic [NW-1:0] TP_N = NW'(TABLE_PAGES);
    localparam logic [39:0]   TP_F = 40'(TABLE_PAGES);

    t_in_item         r_req;
    logic [39:0]      r_base;
    logic [1:0]       r_lvl;
    logic [PW-1:0]    r_cur;
    logic [NW-1:0]    r_nf;
    logic [2:0]       r_st;
    logic [63:0]      r_leaf;
    logic [PW-1:0]    r_fill_page;
    logic [63:0]      r_fill_pat;
    logic             r_split;
    logic [IDX_W-1:0] r_cnt;
    logic             r_ov;
    t_out_item        r_out;

    logic [63:0]      e;
    logic [IDX_W-1:0] idx;
    logic [39:0]      idx_e;
    logic             in_pool;
    logic             alloc_ok;
    logic [39:0]      new_addr;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [63:0]      wdata;

    // Ev decisions.
    logic             d_done, d_fill, d_alloc, d_wr;
    logic [2:0]       d_st;
    logic [63:0]      d_wdata, d_leaf, d_pat;
    logic             d_split;

    // Table store.
    ptme_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (i_cmd.rd),
        .i_raddr({r_cur, idx}),
        .o_rdata(e)
    );

    // Table index of the current level.
    always_comb begin
        case (r_lvl)
            LVL_PML4: idx = r_req.virt_addr[47:39];
            LVL_PDPT: idx = r_req.virt_addr[38:30];
            LVL_PD:   idx = r_req.virt_addr[29:21];
            default:  idx = r_req.virt_addr[20:12];
        endcase
    end

    // Pool page of a table entry and the frame of the next free page.
    assign idx_e    = e[51:12] - r_base;
    assign in_pool  = idx_e < TP_F;
    assign alloc_ok = r_nf < TP_N;
    assign new_addr = r_base + {{(40-NW){1'b0}}, r_nf};

    // Decision for the entry read at the current level.
    always_comb begin
        d_done  = 1'b0;
        d_fill  = 1'b0;
        d_alloc = 1'b0;
        d_wr    = 1'b0;
        d_st    = ST_OK;
        d_wdata = '0;
        d_leaf  = '0;
        d_pat   = '0;
        d_split = 1'b0;
        case (r_req.op)
            OP_MAP4K: begin
                if (r_lvl != LVL_PT) begin
                    if (e[7] || !e[0]) begin
                        if (!alloc_ok) begin
                            d_done = 1'b1;
                            d_st   = ST_EXHAUSTED;
                        end else if (e[7]) begin
                            // A 2M leaf in the way is split into a new table.
                            d_alloc = 1'b1;
                            d_fill  = 1'b1;
                            d_wr    = 1'b1;
                            d_wdata = {e[63], 11'b0, new_addr, 3'b0, e[8], 5'b0,
                                       e[2], e[1], 1'b1};
                            d_pat   = {e[63], 11'b0, e[51:21], 9'b0, 3'b0, e[8],
                                       5'b0, e[2], e[1], e[0]};
                            d_split = 1'b1;
                        end else begin
                            d_alloc = 1'b1;
                            d_fill  = 1'b1;
                            d_wr    = 1'b1;
                            d_wdata = {12'b0, new_addr, 9'b0, r_req.user_access, 2'b11};
                        end
                    end else if (!in_pool) begin
                        d_done = 1'b1;
                        d_st   = ST_NOT_MAPPED;
                    end else begin
                        // Propagate the user bit into a present table entry.
                        d_wr    = r_req.user_access && !e[2];
                        d_wdata = e | 64'h4;
                    end
                end else begin
                    d_done = 1'b1;
                    if (e[0] && (e[51:12] != r_req.phys_addr[51:12])) begin
                        d_st = ST_CONFLICT;
                    end else begin
                        d_wr    = 1'b1;
                        d_wdata = {r_req.no_execute, 11'b0, r_req.phys_addr[51:12],
                                   2'b0, r_req.copy_on_write, r_req.global_page, 5'b0,
                                   r_req.user_access, r_req.write_enable, 1'b1};
                        d_leaf  = d_wdata;
                    end
                end
            end
            OP_MAP2M: begin
                if (r_lvl == LVL_PD) begin
                    d_done  = 1'b1;
                    d_wr    = 1'b1;
                    d_wdata = {1'b1, 11'b0, r_req.phys_addr[51:21], 9'b0, 12'h083};
                    d_leaf  = d_wdata;
                end else if (!e[0]) begin
                    if (!alloc_ok) begin
                        d_done = 1'b1;
                        d_st   = ST_EXHAUSTED;
                    end else begin
                        d_alloc = 1'b1;
                        d_fill  = 1'b1;
                        d_wr    = 1'b1;
                        d_wdata = {12'b0, new_addr, 12'h003};
                    end
                end else if (!in_pool) begin
                    d_done = 1'b1;
                    d_st   = ST_NOT_MAPPED;
                end
            end
            default: begin
                // Unmap: every upper level must be a present table in the pool.
                if (r_lvl != LVL_PT) begin
                    if (!(e[0] && (r_lvl == LVL_PML4 || !e[7]) && in_pool)) begin
                        d_done = 1'b1;
                        d_st   = ST_NOT_MAPPED;
                    end
                end else begin
                    d_done = 1'b1;
                    if (e[0]) begin
                        d_wr = 1'b1;
                    end else begin
                        d_st = ST_NOT_MAPPED;
                    end
                end
            end
        endcase
    end

    // Store write port: fill sweep or the entry of the current level.
    always_comb begin
        if (i_cmd.fill) begin
            we    = 1'b1;
            waddr = {r_fill_page, r_cnt};
            wdata = r_fill_pat | (r_split ? {43'b0, r_cnt, 12'b0} : 64'b0);
        end else begin
            we    = i_cmd.ev && d_wr;
            waddr = {r_cur, idx};
            wdata = d_wdata;
        end
    end

    // Configuration register and walk control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_nf        <= NW'(1);
            r_cnt       <= '0;
            r_fill_page <= '0;
            r_fill_pat  <= '0;
            r_split     <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            if (i_cfg_we) r_base <= i_cfg_data;
            if (i_cmd.fill) r_cnt <= r_cnt + 1'b1;
            if (i_cmd.ev && d_alloc) begin
                r_nf        <= r_nf + 1'b1;
                r_fill_page <= r_nf[PW-1:0];
                r_fill_pat  <= d_pat;
                r_split     <= d_split;
            end
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Request and walk payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_req  <= i_in_item;
            r_st   <= ST_OK;
            r_leaf <= '0;
        end
        if (i_cmd.chk) begin
            r_lvl <= LVL_PML4;
            r_cur <= '0;
            if (o_sts.chk_err) r_st <= ST_UNALIGNED;
        end
        if (i_cmd.ev) begin
            r_st   <= d_st;
            r_leaf <= d_leaf;
            if (!d_done) begin
                r_lvl <= r_lvl - 1'b1;
                r_cur <= d_alloc ? r_nf[PW-1:0] : idx_e[PW-1:0];
            end
        end
        if (i_cmd.out_load) begin
            r_out.status     <= r_st;
            r_out.leaf_entry <= (r_st == ST_OK) ? r_leaf : 64'b0;
        end
    end

    // Status towards the controller.
    always_comb begin
        o_sts.chk_err   = (r_req.op == OP_INVALID) ||
                          (r_req.op != OP_MAP2M && r_req.virt_addr[11:0] != 12'b0) ||
                          (r_req.op == OP_MAP4K && r_req.phys_addr[11:0] != 12'b0);
        o_sts.ev_done   = d_done;
        o_sts.ev_fill   = d_fill;
        o_sts.fill_last = &r_cnt;
        o_sts.out_free  = !r_ov || i_out_ready;
    end

    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;
endmodule
`default_nettype wire
